@@ hdl/clt_pkg.sv @@
// shared types, codes and character classes for the c-like token lexer
`timescale 1ns / 1ps

package clt_pkg;

	// internal offset and length widths
	localparam int OFFSET_BITS = 20;
	localparam int LENGTH_BITS = 16;

	// port widths
	localparam int KIND_W  = 4;
	localparam int START_W = 20;
	localparam int LEN_W   = 16;
	localparam int BYTE_W  = 8;

	// token queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QADDR_W = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

	// token kinds
	localparam logic [KIND_W-1:0] K_UNKNOWN = 4'd0;
	localparam logic [KIND_W-1:0] K_LPAREN  = 4'd1;
	localparam logic [KIND_W-1:0] K_RPAREN  = 4'd2;
	localparam logic [KIND_W-1:0] K_LBRACE  = 4'd3;
	localparam logic [KIND_W-1:0] K_RBRACE  = 4'd4;
	localparam logic [KIND_W-1:0] K_STAR    = 4'd5;
	localparam logic [KIND_W-1:0] K_SEMI    = 4'd6;
	localparam logic [KIND_W-1:0] K_COMMA   = 4'd7;
	localparam logic [KIND_W-1:0] K_IDENT   = 4'd8;
	localparam logic [KIND_W-1:0] K_END     = 4'd9;

	// characters
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_VT     = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_DIG0   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_DIG9   = 8'h39;
	localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UP_Z   = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5F;
	localparam logic [BYTE_W-1:0] CH_LO_A   = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LO_Z   = 8'h7A;
	localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [OFFSET_BITS-1:0] start;
		logic [LENGTH_BITS-1:0] length;
	} token_t;

	// everything one byte produces: one token, or two when two is set
	typedef struct packed {
		logic   two;
		token_t tok0;
		token_t tok1;
	} entry_t;

	function automatic logic is_space(input logic [BYTE_W-1:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_VT, CH_LF, CH_CR, CH_FF};
	endfunction

	function automatic logic is_ident(input logic [BYTE_W-1:0] c);
		return c inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z], [CH_DIG0:CH_DIG9], CH_UNDER};
	endfunction

	function automatic logic [KIND_W-1:0] punct_kind(input logic [BYTE_W-1:0] c);
		logic [KIND_W-1:0] k;
		case (c)
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_LBRACE: k = K_LBRACE;
			CH_RBRACE: k = K_RBRACE;
			CH_STAR:   k = K_STAR;
			CH_SEMI:   k = K_SEMI;
			CH_COMMA:  k = K_COMMA;
			default:   k = K_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

@@ hdl/c_like_token_lexer.sv @@
// top level of the c-like token lexer: scanner, token queue and output stage
`timescale 1ns / 1ps

// Streaming lexer for a C-like text. One byte enters per transaction on the
// text channel and byte 0 ends the stream. Whitespace, // line comments (up
// to CR or LF) and /* */ block comments are skipped, any number in a row.
// Each token leaves as one transaction on the token channel with its kind
// (0 unknown, 1 '(', 2 ')', 3 '{', 4 '}', 5 '*', 6 ';', 7 ',', 8 identifier,
// 9 end of stream), the offset of its first byte (wrapping at 2^20) and its
// length (saturating at 65535, 1 for single characters and the end token).
// last_of_run marks the final token caused by one input byte; a byte that
// closes an identifier or a lone slash can cause two. The scanner accepts
// one byte every cycle while text_stall is low. Tokens leave at one per cycle
// from the output register while token_stall is low, so a byte that causes
// two tokens holds the output for both in turn, and a four-entry queue
// between scanner and output absorbs such bursts and token stalls until it
// fills. text_stall rises only when that queue is full. With the queue empty
// and the output free, a token is presented on the output from the clock
// edge that follows the one accepting the byte that completes it. After the
// end token all scanner state, the byte offset included, is back at reset.

module c_like_token_lexer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         text_valid,
	output logic                         text_stall,
	input  logic [clt_pkg::BYTE_W-1:0]   text_byte,
	output logic                         token_valid,
	input  logic                         token_stall,
	output logic [clt_pkg::KIND_W-1:0]   token_kind,
	output logic [clt_pkg::START_W-1:0]  token_start,
	output logic [clt_pkg::LEN_W-1:0]    token_length,
	output logic                         last_of_run
);

	logic            accept;
	logic            push;
	logic            pop;
	logic            full;
	logic            nonempty;
	clt_pkg::entry_t wr_entry;
	clt_pkg::entry_t rd_entry;

	// a byte transaction completes whenever the queue has room
	assign text_stall = full;
	assign accept     = text_valid && !full;

	// scanner: comment and identifier tracking, token formation
	clt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_byte (text_byte),
		.push      (push),
		.entry     (wr_entry)
	);

	// decouples the scanner from output stalls
	clt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.rd_entry (rd_entry)
	);

	// output stage: one token per transaction
	clt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.nonempty     (nonempty),
		.rd_entry     (rd_entry),
		.pop          (pop),
		.token_stall  (token_stall),
		.token_valid  (token_valid),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

endmodule

@@ hdl/clt_front.sv @@
// lexer front: scanner state machine that turns one byte into up to two tokens
`timescale 1ns / 1ps

module clt_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [clt_pkg::BYTE_W-1:0]  text_byte,
	output logic                        push,
	output clt_pkg::entry_t             entry
);

	localparam logic [2:0] M_NORMAL = 3'd0;
	localparam logic [2:0] M_IDENT  = 3'd1;
	localparam logic [2:0] M_SLASH  = 3'd2;
	localparam logic [2:0] M_LINE   = 3'd3;
	localparam logic [2:0] M_BLOCK  = 3'd4;
	localparam logic [2:0] M_BSTAR  = 3'd5;

	logic [2:0]                        mode_q, mode_d;
	logic [clt_pkg::OFFSET_BITS-1:0]   pos_q, pos_d;
	logic [clt_pkg::OFFSET_BITS-1:0]   pend_q, pend_d;
	logic [clt_pkg::LENGTH_BITS-1:0]   cnt_q, cnt_d;

	logic                              do_normal;
	logic                              end_hit;
	logic                              pre_valid, post_valid;
	clt_pkg::token_t                   pre_tok, post_tok;
	logic [clt_pkg::KIND_W-1:0]        pk;

	always_comb begin
		mode_d     = mode_q;
		pend_d     = pend_q;
		cnt_d      = cnt_q;
		pos_d      = pos_q + 1'b1;
		do_normal  = 1'b0;
		end_hit    = 1'b0;
		pre_valid  = 1'b0;
		post_valid = 1'b0;
		pre_tok    = '{kind: clt_pkg::K_IDENT, start: pend_q, length: cnt_q};
		post_tok   = '{kind: clt_pkg::K_UNKNOWN, start: pos_q, length: clt_pkg::LEN_ONE};
		pk         = clt_pkg::punct_kind(text_byte);

		case (mode_q)
			M_IDENT: begin
				if (clt_pkg::is_ident(text_byte)) begin
					if (cnt_q != clt_pkg::LEN_MAX) begin
						cnt_d = cnt_q + 1'b1;
					end
				end else begin
					pre_valid = 1'b1;
					do_normal = 1'b1;
				end
			end
			M_SLASH: begin
				if (text_byte == clt_pkg::CH_SLASH) begin
					mode_d = M_LINE;
				end else if (text_byte == clt_pkg::CH_STAR) begin
					mode_d = M_BLOCK;
				end else begin
					// lone slash
					pre_valid  = 1'b1;
					pre_tok    = '{kind: clt_pkg::K_UNKNOWN, start: pend_q,
						length: clt_pkg::LEN_ONE};
					do_normal  = 1'b1;
				end
			end
			M_LINE: begin
				if (text_byte == clt_pkg::CH_NUL) begin
					do_normal = 1'b1;
				end else if (text_byte == clt_pkg::CH_CR || text_byte == clt_pkg::CH_LF) begin
					mode_d = M_NORMAL;
				end
			end
			M_BLOCK: begin
				if (text_byte == clt_pkg::CH_NUL) begin
					do_normal = 1'b1;
				end else if (text_byte == clt_pkg::CH_STAR) begin
					mode_d = M_BSTAR;
				end
			end
			M_BSTAR: begin
				if (text_byte == clt_pkg::CH_NUL) begin
					do_normal = 1'b1;
				end else if (text_byte == clt_pkg::CH_SLASH) begin
					mode_d = M_NORMAL;
				end else if (text_byte != clt_pkg::CH_STAR) begin
					mode_d = M_BLOCK;
				end
			end
			default: begin
				do_normal = 1'b1;
			end
		endcase

		// between tokens
		if (do_normal) begin
			mode_d = M_NORMAL;
			if (text_byte == clt_pkg::CH_NUL) begin
				post_valid    = 1'b1;
				post_tok.kind = clt_pkg::K_END;
				end_hit       = 1'b1;
			end else if (clt_pkg::is_space(text_byte)) begin
				post_valid = 1'b0;
			end else if (text_byte == clt_pkg::CH_SLASH) begin
				mode_d = M_SLASH;
				pend_d = pos_q;
			end else if (pk != clt_pkg::K_UNKNOWN) begin
				post_valid    = 1'b1;
				post_tok.kind = pk;
			end else if (clt_pkg::is_ident(text_byte)) begin
				mode_d = M_IDENT;
				pend_d = pos_q;
				cnt_d  = clt_pkg::LEN_ONE;
			end else begin
				post_valid = 1'b1;
			end
		end

		// end of stream returns everything to reset
		if (end_hit) begin
			mode_d = M_NORMAL;
			pos_d  = '0;
			pend_d = '0;
			cnt_d  = '0;
		end
	end

	assign push       = accept && (pre_valid || post_valid);
	assign entry.two  = pre_valid && post_valid;
	assign entry.tok0 = pre_valid ? pre_tok : post_tok;
	assign entry.tok1 = post_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			pos_q  <= '0;
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			pend_q <= pend_d;
			cnt_q  <= cnt_d;
		end
	end

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_hit |=> pos_q == '0 && mode_q == M_NORMAL && cnt_q == '0)
		else $error("state not cleared after end of stream");

	a_ident_len: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_IDENT |-> cnt_q != '0)
		else $error("open identifier with zero length");

endmodule

@@ hdl/clt_queue.sv @@
// small token queue between the scanner and the output serializer
`timescale 1ns / 1ps

module clt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  clt_pkg::entry_t wr_entry,
	input  logic            pop,
	output logic            full,
	output logic            nonempty,
	output clt_pkg::entry_t rd_entry
);

	clt_pkg::entry_t                 slot_q [clt_pkg::QDEPTH];
	logic [clt_pkg::QADDR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [clt_pkg::QCNT_W-1:0]      count_q;

	assign full     = count_q == clt_pkg::QCNT_W'(clt_pkg::QDEPTH);
	assign nonempty = count_q != '0;
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= clt_pkg::QCNT_W'(clt_pkg::QDEPTH))
		else $error("token queue count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("token queue count did not follow a push");

endmodule

@@ hdl/clt_back.sv @@
// lexer back: splits queue entries into single tokens behind an output register
`timescale 1ns / 1ps

module clt_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         nonempty,
	input  clt_pkg::entry_t              rd_entry,
	output logic                         pop,
	input  logic                         token_stall,
	output logic                         token_valid,
	output logic [clt_pkg::KIND_W-1:0]   token_kind,
	output logic [clt_pkg::START_W-1:0]  token_start,
	output logic [clt_pkg::LEN_W-1:0]    token_length,
	output logic                         last_of_run
);

	logic            valid_q;
	logic            last_q;
	logic            hold_q;
	clt_pkg::token_t tok_q;
	clt_pkg::token_t hold_tok_q;
	logic            advance;

	// output register free to load this cycle
	assign advance = !valid_q || !token_stall;
	assign pop     = advance && !hold_q && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			hold_q  <= 1'b0;
		end else if (advance) begin
			if (hold_q) begin
				valid_q <= 1'b1;
				last_q  <= 1'b1;
				hold_q  <= 1'b0;
			end else if (nonempty) begin
				valid_q <= 1'b1;
				last_q  <= !rd_entry.two;
				hold_q  <= rd_entry.two;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (hold_q) begin
				tok_q <= hold_tok_q;
			end else if (nonempty) begin
				tok_q      <= rd_entry.tok0;
				hold_tok_q <= rd_entry.tok1;
			end
		end
	end

	assign token_valid  = valid_q;
	assign token_kind   = tok_q.kind;
	assign token_start  = clt_pkg::START_W'(tok_q.start);
	assign token_length = clt_pkg::LEN_W'(tok_q.length);
	assign last_of_run  = last_q;

	a_hold_behind_valid: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q |-> valid_q && !last_q)
		else $error("second token pending behind a final or empty output");

	a_no_pop_while_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q |-> !pop)
		else $error("queue popped while a second token is pending");

endmodule
